/* rtl/pgwalk_pkg.sv */
// Shared constants, the state type and a helper function for the page table walker.
package pgwalk_pkg;

	localparam int POOL_PAGES_DEF = 16;

	localparam int CMD_W   = 2;
	localparam int VA_W    = 48;
	localparam int PA_W    = 52;
	localparam int FLAGS_W = 12;
	localparam int STAT_W  = 2;

	localparam int IDX_W   = 9;
	localparam int OFF_W   = 12;
	localparam int ENTRY_W = 52;
	localparam int PN_W    = ENTRY_W - OFF_W;

	localparam logic [CMD_W-1:0] CMD_MAP   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_XLATE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISSING  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_PAGES = 2'd2;

	// Present and writable, as set on every link entry.
	localparam logic [OFF_W-1:0] LINK_FLAGS = 12'h003;

	localparam logic [1:0] LVL_LEAF = 2'd3;
	localparam logic [1:0] LVL_LAST_LINK = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CHECK,
		S_WRITE,
		S_DONE
	} state_t;

	// Table index for one level of the walk, highest level first.
	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
			input logic [1:0] level);
		logic [IDX_W-1:0] idx;
		unique case (level)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			2'd3: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

/* rtl/pgwalk_mem.sv */
// Single-port table store with a registered read port.
module pgwalk_mem
	import pgwalk_pkg::*;
#(
	parameter int POOL_PAGES = POOL_PAGES_DEF,
	localparam int DEPTH = POOL_PAGES * (1 << IDX_W),
	localparam int ADDR_W = $clog2(POOL_PAGES) + IDX_W
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  addr,
	input  logic [ENTRY_W-1:0] wdata,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[addr];
	end

endmodule

/* rtl/pgwalk_seq.sv */
// Walk sequencer: clearing sweep, level-by-level table walk, allocation and results.
module pgwalk_seq
	import pgwalk_pkg::*;
#(
	parameter int POOL_PAGES = POOL_PAGES_DEF,
	localparam int PG_W = $clog2(POOL_PAGES),
	localparam int NF_W = $clog2(POOL_PAGES + 1),
	localparam int DEPTH = POOL_PAGES * (1 << IDX_W),
	localparam int ADDR_W = PG_W + IDX_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [VA_W-1:0]    virt_addr,
	input  logic [PA_W-1:0]    phys_addr,
	input  logic [FLAGS_W-1:0] entry_flags,
	output logic               done,
	output logic [PA_W-1:0]    result_addr,
	output logic [STAT_W-1:0]  status,
	output logic               mem_we,
	output logic [ADDR_W-1:0]  mem_addr,
	output logic [ENTRY_W-1:0] mem_wdata,
	input  logic [ENTRY_W-1:0] mem_rdata
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0]     clr_cnt_q;
	logic [NF_W-1:0]       nfp_q;
	logic [1:0]            level_q;
	logic [PG_W-1:0]       page_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [VA_W-1:0]       va_q;
	logic [PN_W-1:0]       frame_q;
	logic [FLAGS_W-1:0]    flags_q;
	logic [PA_W-1:0]       result_addr_q;
	logic [STAT_W-1:0]     status_q;

	logic [IDX_W-1:0] cur_idx;
	logic             link_ok;
	logic [PG_W-1:0]  link_pg;
	logic             pool_full;
	logic             alloc;
	logic             take;
	logic             cmd_known;

	// The shared check unit: index selection and link validation for the current level.
	assign cur_idx   = level_index(va_q, level_q);
	assign link_ok   = mem_rdata[0]
		&& (mem_rdata[ENTRY_W-1:OFF_W] < PN_W'(POOL_PAGES));
	assign link_pg   = mem_rdata[OFF_W +: PG_W];
	assign pool_full = nfp_q >= NF_W'(POOL_PAGES);
	assign alloc     = (state_q == S_CHECK) && (level_q != LVL_LEAF)
		&& (cmd_q == CMD_MAP) && !link_ok && !pool_full;
	assign take      = start && !busy;
	assign cmd_known = (cmd == CMD_MAP) || (cmd == CMD_UNMAP) || (cmd == CMD_XLATE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE, S_DONE: begin
				if (start) begin
					state_d = cmd_known ? S_READ : S_DONE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (level_q == LVL_LEAF) begin
					state_d = S_DONE;
				end else if (link_ok || alloc) begin
					if (level_q == LVL_LAST_LINK && cmd_q != CMD_XLATE) begin
						state_d = S_WRITE;
					end else begin
						state_d = S_READ;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_WRITE: begin
				state_d = S_DONE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = !(state_q == S_IDLE || state_q == S_DONE);
		done      = state_q == S_DONE;
		mem_we    = 1'b0;
		mem_addr  = {page_q, cur_idx};
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_cnt_q;
			end
			S_CHECK: begin
				if (alloc) begin
					mem_we    = 1'b1;
					mem_wdata = {PN_W'(nfp_q), LINK_FLAGS};
				end
			end
			S_WRITE: begin
				mem_we = 1'b1;
				if (cmd_q == CMD_MAP) begin
					mem_wdata = {frame_q, flags_q};
				end
			end
			S_IDLE, S_READ, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			nfp_q     <= NF_W'(1);
			level_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			if (alloc) begin
				nfp_q <= nfp_q + NF_W'(1);
			end
			if (take) begin
				level_q <= '0;
			end else if (state_q == S_CHECK && (link_ok || alloc)) begin
				level_q <= level_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q   <= cmd;
			va_q    <= virt_addr;
			frame_q <= phys_addr[PA_W-1:OFF_W];
			flags_q <= entry_flags;
			page_q  <= '0;
			if (!cmd_known) begin
				result_addr_q <= '0;
				status_q      <= STAT_MISSING;
			end
		end
		if (state_q == S_CHECK) begin
			if (level_q == LVL_LEAF) begin
				if (mem_rdata[0]) begin
					result_addr_q <= {mem_rdata[ENTRY_W-1:OFF_W], va_q[OFF_W-1:0]};
					status_q      <= STAT_OK;
				end else begin
					result_addr_q <= '0;
					status_q      <= STAT_MISSING;
				end
			end else if (link_ok) begin
				page_q <= link_pg;
			end else if (alloc) begin
				page_q <= nfp_q[PG_W-1:0];
			end else begin
				result_addr_q <= '0;
				status_q      <= (cmd_q == CMD_MAP) ? STAT_NO_PAGES : STAT_MISSING;
			end
		end
		if (state_q == S_WRITE) begin
			result_addr_q <= '0;
			status_q      <= STAT_OK;
		end
	end

	assign result_addr = result_addr_q;
	assign status      = status_q;

endmodule

/* rtl/four_level_page_table_walker.sv */
// Top level of the four-level page table walker with its internal table pool.
//
// Usage. A command word (cmd, virt_addr, phys_addr, entry_flags) is taken at a rising
// edge where start is high and busy is low. Commands are map, unmap and translate; the
// tables live in an internal pool of POOL_PAGES pages of 512 entries, page zero being the
// root and further pages handed out in order by a bump allocator, never freed.
// Each command gives exactly one result word: done is high for one cycle while
// result_addr and status are valid. The receiver cannot stall the block, so the word
// must be taken in that cycle.
// Walk. The walker reads one table entry per level from a single-port store, one access
// per cycle, in a read state and a check state per level; for a map, a missing table page
// is allocated, while pages remain, and linked in the check state. A map or unmap that
// reaches the leaf ends with one leaf write, a translate with a leaf read; a walk that can
// neither follow nor allocate a link stops after that level's check, and an unknown
// command goes straight to done without a walk. busy is low while done is high, so a new
// word can be taken then, back to back; no word is taken before the previous one is done.
// Reset. After arst_n is released the whole store, POOL_PAGES * 512 entries (8192 at the
// default size), is swept to zero, one entry per cycle; busy is high throughout.
module four_level_page_table_walker
	import pgwalk_pkg::*;
#(
	parameter int POOL_PAGES = POOL_PAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [VA_W-1:0]    virt_addr,
	input  logic [PA_W-1:0]    phys_addr,
	input  logic [FLAGS_W-1:0] entry_flags,
	output logic               done,
	output logic [PA_W-1:0]    result_addr,
	output logic [STAT_W-1:0]  status
);

	// Store address is the page number above the nine-bit table index.
	localparam int ADDR_W = $clog2(POOL_PAGES) + IDX_W;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_addr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] mem_rdata;

	// The sequencer owns the walk, the allocator and the result registers.
	pgwalk_seq #(
		.POOL_PAGES(POOL_PAGES)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.virt_addr(virt_addr),
		.phys_addr(phys_addr),
		.entry_flags(entry_flags),
		.done(done),
		.result_addr(result_addr),
		.status(status),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	// The table store holds link entries and leaf entries alike.
	pgwalk_mem #(
		.POOL_PAGES(POOL_PAGES)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the four-level page table walker.
module tb
	import pgwalk_pkg::*;
;

	// The pool size the block is built with, and the shape of one table page.
	localparam int POOL = POOL_PAGES_DEF;
	localparam int ENTRIES = 512;

	// The command code the block must treat as unknown; the package names only three.
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	// Idle margin at the end of the run, after the last answer has been checked.
	localparam int TAIL_CYCLES = 24;

	// Generous bound on the whole run: the clearing sweep plus every command at its slowest.
	localparam int LIMIT_NS = 3_600_000;

	localparam logic [VA_W-1:0] VA_ALL_ONES = {VA_W{1'b1}};
	localparam logic [PA_W-1:0] PA_ALL_ONES = {PA_W{1'b1}};

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [VA_W-1:0]   va;
		logic [PA_W-1:0]   addr;
		logic [STAT_W-1:0] stat;
	} walk_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   cmd;
	logic [VA_W-1:0]    virt_addr;
	logic [PA_W-1:0]    phys_addr;
	logic [FLAGS_W-1:0] entry_flags;
	logic               done;
	logic [PA_W-1:0]    result_addr;
	logic [STAT_W-1:0]  status;

	// Our own copy of the table pool and the bump allocator, updated as each word is taken.
	logic [ENTRY_W-1:0] shadow_tables [POOL * ENTRIES];
	int unsigned        alloc_next;

	// Expected answers, oldest first, one per accepted command word.
	walk_result_t       pending_walks [$];

	// Addresses mapped recently, so that translates and unmaps often land on live leaves.
	logic [VA_W-1:0]    recent_maps [$];

	int sender_idle_pct;
	int mismatches;
	int words_sent;
	int results_seen;
	int cmd_count [4];
	int status_count [4];

	four_level_page_table_walker uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.entry_flags (entry_flags),
		.done        (done),
		.result_addr (result_addr),
		.status      (status)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor of the table walk.
	// ------------------------------------------------------------------

	// Position in the pool of the entry that one level of the walk reads.
	function automatic int unsigned tbl_pos(input int unsigned page,
			input logic [VA_W-1:0] va, input int lvl);
		return page * ENTRIES + int'((va >> (39 - 9 * lvl)) & 48'h1FF);
	endfunction

	// A link is usable when it is present and names a page inside the pool;
	// anything else counts as a missing table.
	function automatic bit follow_link(input logic [ENTRY_W-1:0] e, output int unsigned pg);
		pg = 0;
		if (!e[0])
			return 1'b0;
		if (e[ENTRY_W-1:OFF_W] >= POOL)
			return 1'b0;
		pg = int'(e[ENTRY_W-1:OFF_W]);
		return 1'b1;
	endfunction

	// Walks the three link levels without allocating and gives the leaf table page.
	function automatic bit find_leaf_table(input logic [VA_W-1:0] va, output int unsigned pg);
		int unsigned nxt;
		pg = 0;
		for (int lvl = 0; lvl < 3; lvl++) begin
			if (!follow_link(shadow_tables[tbl_pos(pg, va, lvl)], nxt))
				return 1'b0;
			pg = nxt;
		end
		return 1'b1;
	endfunction

	// Applies one command word to the shadow tables and gives the answer it must produce.
	function automatic void predict_walk(input logic [CMD_W-1:0] c, input logic [VA_W-1:0] va,
			input logic [PA_W-1:0] pa, input logic [FLAGS_W-1:0] fl,
			output logic [PA_W-1:0] addr, output logic [STAT_W-1:0] stat);
		int unsigned pg;
		int unsigned nxt;
		int unsigned pos;
		logic [ENTRY_W-1:0] leaf;
		addr = '0;
		stat = STAT_MISSING;
		case (c)
			CMD_MAP: begin
				stat = STAT_OK;
				pg = 0;
				for (int lvl = 0; lvl < 3 && stat == STAT_OK; lvl++) begin
					pos = tbl_pos(pg, va, lvl);
					if (!follow_link(shadow_tables[pos], nxt)) begin
						// Tables linked earlier in this same walk stay in place on failure.
						if (alloc_next >= POOL) begin
							stat = STAT_NO_PAGES;
						end else begin
							nxt = alloc_next;
							alloc_next++;
							for (int i = 0; i < ENTRIES; i++)
								shadow_tables[nxt * ENTRIES + i] = '0;
							shadow_tables[pos] = (ENTRY_W'(nxt) << OFF_W) | ENTRY_W'(LINK_FLAGS);
						end
					end
					pg = nxt;
				end
				if (stat == STAT_OK)
					shadow_tables[tbl_pos(pg, va, 3)] = {pa[PA_W-1:OFF_W], fl};
			end
			CMD_UNMAP: begin
				// The leaf is cleared whenever the path exists, present or not.
				if (find_leaf_table(va, pg)) begin
					shadow_tables[tbl_pos(pg, va, 3)] = '0;
					stat = STAT_OK;
				end
			end
			CMD_XLATE: begin
				if (find_leaf_table(va, pg)) begin
					leaf = shadow_tables[tbl_pos(pg, va, 3)];
					if (leaf[0]) begin
						addr = {leaf[ENTRY_W-1:OFF_W], va[OFF_W-1:0]};
						stat = STAT_OK;
					end
				end
			end
			default: begin
				// An unknown command leaves the tables alone and reports a miss.
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driving and checking.
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic [PA_W-1:0] rand_pa();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[PA_W-1:0];
	endfunction

	function automatic logic [VA_W-1:0] rand_va();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[VA_W-1:0];
	endfunction

	// Puts noise on the command fields while start is low, which the block must ignore.
	task automatic idle_cycle();
		@(negedge clk);
		start = 1'b0;
		cmd = CMD_MAP;
		virt_addr = rand_va();
		phys_addr = rand_pa();
		entry_flags = FLAGS_W'($urandom());
	endtask

	// Offers one command word and waits until the block takes it. The word is predicted
	// at the accepting edge, so the answer queue always follows the order of acceptance.
	// start is left high; the next call or the closing idle cycle deals with it at the
	// following falling edge.
	task automatic issue_word(input logic [CMD_W-1:0] c, input logic [VA_W-1:0] va,
			input logic [PA_W-1:0] pa, input logic [FLAGS_W-1:0] fl);
		walk_result_t w;
		while ($urandom_range(99) < sender_idle_pct)
			idle_cycle();
		@(negedge clk);
		start = 1'b1;
		cmd = c;
		virt_addr = va;
		phys_addr = pa;
		entry_flags = fl;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		w.cmd = c;
		w.va = va;
		predict_walk(c, va, pa, fl, w.addr, w.stat);
		pending_walks.push_back(w);
		words_sent++;
		cmd_count[c]++;
	endtask

	// Every result word is checked against the oldest outstanding command. The receiver
	// cannot hold words off, so each one is taken in its single strobe cycle.
	always @(posedge clk) begin
		walk_result_t want;
		if (arst_n && done) begin
			results_seen++;
			status_count[status]++;
			if (pending_walks.size() == 0) begin
				report_mismatch($sformatf("result word addr %h status %0d with nothing outstanding",
					result_addr, status));
			end else begin
				want = pending_walks.pop_front();
				if (result_addr !== want.addr)
					report_mismatch($sformatf("cmd %0d va %h: result_addr %h, expected %h",
						want.cmd, want.va, result_addr, want.addr));
				if (status !== want.stat)
					report_mismatch($sformatf("cmd %0d va %h: status %0d, expected %0d",
						want.cmd, want.va, status, want.stat));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------

	// Upper address bits (levels one to three) of the regions that random traffic maps into.
	// The first two take every upper bit to both values; the others share tables with them.
	localparam int NUM_REGIONS = 5;

	function automatic logic [VA_W-1:0] region_va(input int sel, input logic [20:0] low);
		logic [26:0] hi;
		case (sel)
			0: hi = 27'h0;
			1: hi = 27'h7FF_FFFF;
			2: hi = {9'd0, 9'd0, 9'd1};
			3: hi = {9'd0, 9'd1, 9'd0};
			default: hi = {9'd511, 9'd0, 9'd5};
		endcase
		return {hi, low};
	endfunction

	function automatic logic [VA_W-1:0] random_region_va();
		return region_va($urandom_range(NUM_REGIONS - 1), 21'($urandom()));
	endfunction

	// A recent mapping with a fresh offset, or a random place in a region.
	function automatic logic [VA_W-1:0] pick_live_va(input int hit_pct);
		if (recent_maps.size() != 0 && $urandom_range(99) < hit_pct)
			return {recent_maps[$urandom_range(recent_maps.size() - 1)][VA_W-1:OFF_W],
				12'($urandom())};
		return random_region_va();
	endfunction

	task automatic map_word(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
			input logic [FLAGS_W-1:0] fl);
		issue_word(CMD_MAP, va, pa, fl);
		recent_maps.push_back(va);
		if (recent_maps.size() > 48)
			void'(recent_maps.pop_front());
	endtask

	// Before anything is mapped every walk stops at the root.
	task automatic test_empty_tables();
		issue_word(CMD_XLATE, '0, '0, '0);
		issue_word(CMD_UNMAP, VA_ALL_ONES, PA_ALL_ONES, '1);
		issue_word(CMD_UNKNOWN, VA_ALL_ONES, PA_ALL_ONES, '1);
	endtask

	// Maps at both ends of the address space, then overwrites an existing leaf.
	task automatic test_map_extremes();
		map_word('0, PA_ALL_ONES, 12'hFFF);
		issue_word(CMD_XLATE, 48'hFFF, '0, '0);
		map_word(VA_ALL_ONES, '0, 12'h001);
		issue_word(CMD_XLATE, VA_ALL_ONES, PA_ALL_ONES, '1);
		map_word(VA_ALL_ONES, rand_pa(), 12'h003);
		issue_word(CMD_XLATE, {VA_ALL_ONES[VA_W-1:OFF_W], 12'h000}, '0, '0);
	endtask

	// A leaf without its present bit can be written and cleared but never translates.
	task automatic test_non_present_leaf();
		map_word(48'h5000, rand_pa(), 12'h002);
		issue_word(CMD_XLATE, 48'h5ABC, '0, '0);
		issue_word(CMD_UNMAP, 48'h5000, '0, '0);
		issue_word(CMD_UNMAP, '0, '0, '0);
		issue_word(CMD_XLATE, 48'h123, '0, '0);
		issue_word(CMD_UNMAP, '0, '0, '0);
	endtask

	// Builds the remaining regions, then walks into paths that break at the middle levels.
	task automatic test_partial_paths();
		map_word(region_va(2, 21'h1FF123), rand_pa(), 12'h801);
		map_word(region_va(3, 21'h000FFF), rand_pa(), 12'h7FF);
		map_word(region_va(4, 21'h0AA000), rand_pa(), 12'h003);
		issue_word(CMD_XLATE, {9'd0, 9'd2, 30'h0}, '0, '0);
		issue_word(CMD_UNMAP, {9'd0, 9'd0, 9'd7, 21'h0}, '0, '0);
		issue_word(CMD_UNKNOWN, '0, '0, '0);
	endtask

	// Mostly well-formed traffic within the regions; the rest is noise that misses.
	// With fresh_pct above zero some maps also go to random addresses and need new tables.
	task automatic test_random_mix(input int items, input int idle_pct, input int fresh_pct);
		int sel;
		logic [FLAGS_W-1:0] fl;
		sender_idle_pct = idle_pct;
		for (int n = 0; n < items; n++) begin
			sel = $urandom_range(99);
			fl = FLAGS_W'($urandom());
			if ($urandom_range(3) != 0)
				fl[0] = 1'b1;
			if (sel < fresh_pct)
				map_word(rand_va(), rand_pa(), fl);
			else if (sel < 40)
				map_word(random_region_va(), rand_pa(), fl);
			else if (sel < 70)
				issue_word(CMD_XLATE, pick_live_va(70), rand_pa(), fl);
			else if (sel < 88)
				issue_word(CMD_UNMAP, pick_live_va(60), rand_pa(), fl);
			else if (sel < 96)
				issue_word($urandom_range(1) ? CMD_XLATE : CMD_UNMAP, rand_va(), rand_pa(), fl);
			else
				issue_word(CMD_UNKNOWN, rand_va(), rand_pa(), fl);
		end
	endtask

	// Spends the pool one table at a time until two pages are left, then asks for a walk
	// that needs three: two get linked and the map fails. Later maps needing a page fail
	// too, while maps over existing tables still succeed.
	task automatic test_pool_exhaustion();
		int unsigned l1_page;
		int unsigned l2_page;
		int unsigned ix;
		logic [VA_W-1:0] va;
		sender_idle_pct = 20;
		void'(follow_link(shadow_tables[0], l1_page));
		void'(follow_link(shadow_tables[l1_page * ENTRIES], l2_page));
		while (int'(POOL) - int'(alloc_next) > 2) begin
			do
				ix = $urandom_range(ENTRIES - 1);
			while (shadow_tables[l2_page * ENTRIES + ix][0]);
			map_word({9'd0, 9'd0, ix[8:0], 21'($urandom())}, rand_pa(), 12'h001);
		end
		do
			ix = $urandom_range(ENTRIES - 1);
		while (shadow_tables[ix][0]);
		va = {ix[8:0], 39'($urandom())};
		issue_word(CMD_MAP, va, rand_pa(), 12'h003);
		issue_word(CMD_MAP, va, rand_pa(), 12'h003);
		issue_word(CMD_XLATE, va, '0, '0);
		issue_word(CMD_UNMAP, va, '0, '0);
		map_word(region_va(2, 21'($urandom())), rand_pa(), 12'h001);
		issue_word(CMD_XLATE, recent_maps[recent_maps.size() - 1], '0, '0);
	endtask

	// ------------------------------------------------------------------
	// Run sequence.
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_MAP;
		virt_addr = '0;
		phys_addr = '0;
		entry_flags = '0;
		sender_idle_pct = 0;
		mismatches = 0;
		words_sent = 0;
		results_seen = 0;
		foreach (cmd_count[i]) cmd_count[i] = 0;
		foreach (status_count[i]) status_count[i] = 0;
		foreach (shadow_tables[i]) shadow_tables[i] = '0;
		alloc_next = 1;

		// Reset is released at a falling edge; the first word then waits out the sweep
		// that clears the pool, since busy stays high until it is over.
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_empty_tables();
		test_map_extremes();
		test_non_present_leaf();
		test_partial_paths();

		// Back to back, then a sparse sender, then a lightly idling one.
		test_random_mix(400, 0, 0);
		test_random_mix(330, 83, 0);
		test_random_mix(330, 20, 0);

		test_pool_exhaustion();
		test_random_mix(150, 20, 3);

		idle_cycle();
		while (pending_walks.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d words (map %0d, unmap %0d, translate %0d, unknown %0d); %0d answers.",
			words_sent, cmd_count[CMD_MAP], cmd_count[CMD_UNMAP], cmd_count[CMD_XLATE],
			cmd_count[CMD_UNKNOWN], results_seen);
		$display("Answers: ok %0d, missing %0d, out of pages %0d; %0d of %0d table pages used.",
			status_count[STAT_OK], status_count[STAT_MISSING], status_count[STAT_NO_PAGES],
			alloc_next, POOL);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: a stuck handshake or a missing answer ends the run here.
	initial begin
		#(LIMIT_NS);
		$display("Watchdog expired with %0d answers outstanding.", pending_walks.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
rtl/pgwalk_pkg.sv
rtl/pgwalk_mem.sv
rtl/pgwalk_seq.sv
rtl/four_level_page_table_walker.sv
dv/tb.sv
